@@ rtl/core/ssa_pkg.sv @@
// Shared widths, register indexes and item layouts for the segment stats aggregator.
package ssa_pkg;

  // Statistics sizing
  localparam int COUNT_BITS    = 20;
  localparam int SPEED_BITS    = 16;
  localparam int MEAN_BITS     = SPEED_BITS;
  localparam int SUM_BITS      = COUNT_BITS + SPEED_BITS;
  localparam int DIV_STEP_BITS = $clog2(MEAN_BITS + 1);

  // Field widths
  localparam int LAP_BITS   = 16;
  localparam int MS_BITS    = 24;
  localparam int DELTA_BITS = 24;
  localparam int REC_BITS   = 16;

  // Configuration port
  localparam int CFG_ADDR_BITS = 1;
  localparam int CFG_DATA_BITS = 16;
  localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_RECORDS      = CFG_ADDR_BITS'(0);
  localparam logic [CFG_ADDR_BITS-1:0] REG_MOVING_THRESHOLD = CFG_ADDR_BITS'(1);

  localparam logic [REC_BITS-1:0]   MAX_RECORDS_RESET = REC_BITS'(64);
  localparam logic [SPEED_BITS-1:0] THRESHOLD_RESET   = SPEED_BITS'(10);
  localparam logic [COUNT_BITS-1:0] COUNT_MAX         = {COUNT_BITS{1'b1}};

  // Input sample, lap_id in the low bits and split_two_ms in the high bits
  typedef struct packed {
    logic [MS_BITS-1:0]           split_two_ms;
    logic [MS_BITS-1:0]           split_one_ms;
    logic signed [DELTA_BITS-1:0] delta_time_ms;
    logic [SPEED_BITS-1:0]        speed_tenths;
    logic [MS_BITS-1:0]           elapsed_lap_ms;
    logic [LAP_BITS-1:0]          lap_id;
  } ssa_sample_t;

  // Lap record, closed_lap in the low bits and final_split_two in the high bits
  typedef struct packed {
    logic [MS_BITS-1:0]           final_split_two;
    logic [MS_BITS-1:0]           final_split_one;
    logic [MEAN_BITS-1:0]         mean_speed;
    logic [SPEED_BITS-1:0]        peak_speed;
    logic signed [DELTA_BITS-1:0] closed_delta_ms;
    logic [MS_BITS-1:0]           closed_lap_ms;
    logic [LAP_BITS-1:0]          closed_lap;
  } ssa_record_t;

  localparam int SAMPLE_BITS = $bits(ssa_sample_t);
  localparam int RECORD_BITS = $bits(ssa_record_t);

  // Request to the mean divider
  typedef struct packed {
    logic                  start;
    logic [SUM_BITS-1:0]   dividend;
    logic [COUNT_BITS-1:0] divisor;
  } ssa_div_req_t;

endpackage

@@ rtl/core/ssa_divider.sv @@
// Restoring divider for the lap mean, one quotient bit per cycle.
module ssa_divider (
  input  logic                                clk,
  input  logic                                rst,
  input  ssa_pkg::ssa_div_req_t               req,
  output logic                                done,
  output logic [ssa_pkg::MEAN_BITS-1:0]       quotient
);

  // The mean never exceeds the largest speed, so the dividend's upper part
  // is already below the divisor and only MEAN_BITS steps are needed.
  logic [ssa_pkg::COUNT_BITS-1:0]    rem;
  logic [ssa_pkg::MEAN_BITS-1:0]     lo;
  logic [ssa_pkg::COUNT_BITS-1:0]    divisor;
  logic [ssa_pkg::DIV_STEP_BITS-1:0] step;
  logic                              busy;

  logic [ssa_pkg::COUNT_BITS:0] trial;
  logic                         fits;

  // One trial subtract
  always_comb begin
    trial = {rem, lo[ssa_pkg::MEAN_BITS-1]};
    fits  = trial >= {1'b0, divisor};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem     <= req.dividend[ssa_pkg::SUM_BITS-1:ssa_pkg::MEAN_BITS];
        lo      <= req.dividend[ssa_pkg::MEAN_BITS-1:0];
        divisor <= req.divisor;
        step    <= '0;
        busy    <= 1'b1;
      end else if (busy) begin
        if (fits) begin
          rem <= ssa_pkg::COUNT_BITS'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[ssa_pkg::COUNT_BITS-1:0];
        end
        lo   <= {lo[ssa_pkg::MEAN_BITS-2:0], fits};
        step <= step + 1'b1;
        if (step == ssa_pkg::DIV_STEP_BITS'(ssa_pkg::MEAN_BITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = lo;

endmodule

@@ rtl/core/segment_stats_aggregator.sv @@
// Top level of the segment stats aggregator: lap tracking, statistics and record output.

// Takes one telemetry sample per request and emits a record when the lap number
// moves away from a nonzero lap. A sample that closes no lap, or one taken after
// the record limit, is absorbed without leaving the idle state. A sample that
// closes a lap runs the mean divider, one quotient bit per step, then loads the
// output register before the next sample is taken; with no moving samples in
// the lap the divider is skipped. The output register holds a finished record
// while new samples are accepted; a second closing sample is accepted, but its
// record and all later samples wait until the first record has been taken.
module segment_stats_aggregator (
  input  logic                                clk,
  input  logic                                rst,
  // Configuration writes
  input  logic                                cfg_we,
  input  logic [ssa_pkg::CFG_ADDR_BITS-1:0]   cfg_addr,
  input  logic [ssa_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
  // Samples in
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // lap_id, elapsed_lap_ms, speed_tenths, delta_time_ms, split_one_ms, split_two_ms
  input  logic [ssa_pkg::SAMPLE_BITS-1:0]     s_tdata,
  // Lap records out
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // closed_lap, closed_lap_ms, closed_delta_ms, peak_speed, mean_speed,
  // final_split_one, final_split_two
  output logic [ssa_pkg::RECORD_BITS-1:0]     m_tdata
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_LOAD
  } state_t;

  state_t state;

  // Configuration
  logic [ssa_pkg::REC_BITS-1:0]   max_records;
  logic [ssa_pkg::SPEED_BITS-1:0] moving_threshold;

  // Lap state
  logic [ssa_pkg::LAP_BITS-1:0]   prev_lap;
  logic [ssa_pkg::MS_BITS-1:0]    prev_lap_ms;
  logic [ssa_pkg::SPEED_BITS-1:0] lap_peak;
  logic [ssa_pkg::SUM_BITS-1:0]   moving_sum;
  logic [ssa_pkg::COUNT_BITS-1:0] moving_count;
  logic [ssa_pkg::MS_BITS-1:0]    prev_split_one;
  logic [ssa_pkg::MS_BITS-1:0]    prev_split_two;
  logic [ssa_pkg::REC_BITS-1:0]   records_sent;

  // Pending record and output register
  ssa_pkg::ssa_record_t rec;
  logic                 mean_zero;
  ssa_pkg::ssa_record_t out_rec;
  ssa_pkg::ssa_record_t out_rec_next;
  logic                 out_valid;
  logic                 out_load;

  ssa_pkg::ssa_sample_t sample;
  logic                 accept;
  logic                 limit_hit;
  logic                 closing;

  logic [ssa_pkg::SPEED_BITS-1:0] peak_base;
  logic [ssa_pkg::SUM_BITS-1:0]   sum_base;
  logic [ssa_pkg::COUNT_BITS-1:0] count_base;
  logic [ssa_pkg::SPEED_BITS-1:0] lap_peak_next;
  logic [ssa_pkg::SUM_BITS-1:0]   moving_sum_next;
  logic [ssa_pkg::COUNT_BITS-1:0] moving_count_next;

  ssa_pkg::ssa_div_req_t          div_req;
  logic                           div_done;
  logic [ssa_pkg::MEAN_BITS-1:0]  div_quotient;

  assign sample   = ssa_pkg::ssa_sample_t'(s_tdata);
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;
  assign m_tdata  = out_rec;

  // Lap close decision, folding of the sample into the statistics and the divider request
  always_comb begin
    limit_hit = records_sent >= max_records;
    closing   = (prev_lap != '0) && (sample.lap_id != prev_lap);

    peak_base  = closing ? '0 : lap_peak;
    sum_base   = closing ? '0 : moving_sum;
    count_base = closing ? '0 : moving_count;

    lap_peak_next = (sample.speed_tenths > peak_base) ? sample.speed_tenths : peak_base;
    if ((sample.speed_tenths > moving_threshold) && (count_base < ssa_pkg::COUNT_MAX)) begin
      moving_sum_next   = sum_base + ssa_pkg::SUM_BITS'(sample.speed_tenths);
      moving_count_next = count_base + 1'b1;
    end else begin
      moving_sum_next   = sum_base;
      moving_count_next = count_base;
    end

    div_req.start    = accept && !limit_hit && closing && (moving_count != '0);
    div_req.dividend = moving_sum;
    div_req.divisor  = moving_count;
  end

  // Output register load, mean patched in from the divider, or zero with no moving samples
  always_comb begin
    out_load                = (state == ST_LOAD) && (!out_valid || m_tready);
    out_rec_next            = rec;
    out_rec_next.mean_speed = mean_zero ? '0 : div_quotient;
  end

  ssa_divider u_divider (
    .clk      (clk),
    .rst      (rst),
    .req      (div_req),
    .done     (div_done),
    .quotient (div_quotient)
  );

  // Sequencer, configuration and lap state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      out_valid        <= 1'b0;
      max_records      <= ssa_pkg::MAX_RECORDS_RESET;
      moving_threshold <= ssa_pkg::THRESHOLD_RESET;
      prev_lap         <= '0;
      prev_lap_ms      <= '0;
      lap_peak         <= '0;
      moving_sum       <= '0;
      moving_count     <= '0;
      prev_split_one   <= '0;
      prev_split_two   <= '0;
      records_sent     <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          ssa_pkg::REG_MAX_RECORDS:      max_records      <= cfg_wdata;
          ssa_pkg::REG_MOVING_THRESHOLD: moving_threshold <= cfg_wdata;
          default: ;
        endcase
      end

      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (accept && !limit_hit) begin
            if (closing) begin
              rec.closed_lap      <= prev_lap;
              rec.closed_lap_ms   <= prev_lap_ms;
              rec.closed_delta_ms <= sample.delta_time_ms;
              rec.peak_speed      <= lap_peak;
              rec.mean_speed      <= '0;
              rec.final_split_one <= prev_split_one;
              rec.final_split_two <= prev_split_two;
              mean_zero           <= (moving_count == '0);
              records_sent        <= records_sent + 1'b1;
              state               <= (moving_count == '0) ? ST_LOAD : ST_DIVIDE;
            end
            lap_peak       <= lap_peak_next;
            moving_sum     <= moving_sum_next;
            moving_count   <= moving_count_next;
            prev_lap       <= sample.lap_id;
            prev_lap_ms    <= sample.elapsed_lap_ms;
            prev_split_one <= sample.split_one_ms;
            prev_split_two <= sample.split_two_ms;
          end
        end
        ST_DIVIDE: begin
          if (div_done) begin
            state <= ST_LOAD;
          end
        end
        ST_LOAD: begin
          // Wait for the output register to free up
          if (out_load) begin
            out_rec <= out_rec_next;
            state   <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

@@ rtl/core/ssa_checker.sv @@
// Port-level checks for the segment stats aggregator, bound to the top level.
module ssa_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            m_tvalid,
  input logic                            m_tready,
  input logic [ssa_pkg::RECORD_BITS-1:0] m_tdata
);

  ssa_pkg::ssa_record_t rec;
  assign rec = ssa_pkg::ssa_record_t'(m_tdata);

  // A stalled record holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("record changed while stalled");

  // Mean covers only speeds the peak has seen
  a_mean_le_peak: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> rec.mean_speed <= rec.peak_speed)
    else $error("mean speed above peak speed");

  // Lap zero never closes
  a_lap_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> rec.closed_lap != '0)
    else $error("record for lap zero");

  // Nothing leaves right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("record valid after reset");

endmodule

bind segment_stats_aggregator ssa_checker u_ssa_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
